// ===== rtl/lfl_pkg.sv =====
// shared types and constants of the text line filter
// no dependencies, imported by every module of the block
`timescale 1ns / 1ps

package lfl_pkg;

  // line number width in decimal digits
  localparam int NumberDigits = 6;

  // queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  // byte codes
  localparam logic [7:0] ChNewline  = 8'd10;
  localparam logic [7:0] ChTab      = 8'd9;
  localparam logic [7:0] ChSpace    = 8'd32;
  localparam logic [7:0] ChCaret    = 8'd94;
  localparam logic [7:0] ChDollar   = 8'd36;
  localparam logic [7:0] ChUpperI   = 8'd73;
  localparam logic [7:0] ChQuestion = 8'd63;
  localparam logic [7:0] ChDel      = 8'd127;
  localparam logic [7:0] ChZero     = 8'd48;
  localparam logic [7:0] CaretOfs   = 8'd64;

  // register indexes
  localparam logic [2:0] RegSqueezeBlank   = 3'd0;
  localparam logic [2:0] RegNumberAll      = 3'd1;
  localparam logic [2:0] RegNumberNonblank = 3'd2;
  localparam logic [2:0] RegShowEnds       = 3'd3;
  localparam logic [2:0] RegShowTabs       = 3'd4;
  localparam logic [2:0] RegShowNonprint   = 3'd5;

  typedef struct packed {
    logic squeeze_blank;
    logic number_all;
    logic number_nonblank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/lfl_fifo.sv =====
// short register queue between the classifying front and the emitting back
// depends on lfl_pkg for depth and status type
`timescale 1ns / 1ps

module lfl_fifo #(
  parameter int Width = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [Width-1:0]      data_i,
  input  logic                  pop_i,
  output logic [Width-1:0]      data_o,
  output lfl_pkg::q_status_t    status_o
);
  import lfl_pkg::*;

  logic [Width-1:0]     mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i & ~status_o.full;
    do_pop   = pop_i & ~status_o.empty;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push & ~do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop & ~do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lfl_front.sv =====
// front end: accepts bytes, tracks line state and the bcd line counter,
// and queues a command per byte that is not squeezed; depends on lfl_pkg
`timescale 1ns / 1ps

module lfl_front #(
  parameter int NumDigits = lfl_pkg::NumberDigits,
  parameter int EntryW    = 1 + 4 * NumDigits + 1 + 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfl_pkg::cfg_t       cfg_i,
  input  logic                push_i,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [EntryW-1:0]   q_data_o
);
  import lfl_pkg::*;

  localparam int BcdW = 4 * NumDigits;

  logic            prev_nl_q, prev_nl_d;
  logic            prev_empty_q, prev_empty_d;
  logic [BcdW-1:0] bcd_q, bcd_d, bcd_inc;

  logic       accept, is_nl, cur_empty, drop, num;
  logic       two;
  logic [7:0] b0, b1;
  logic       all_nines, low_nines;

  always_comb begin
    accept    = push_i & ~q_full_i;
    is_nl     = (in_byte_i == ChNewline);
    cur_empty = is_nl & prev_nl_q;
    drop      = cfg_i.squeeze_blank & prev_empty_q & cur_empty;
    num       = prev_nl_q & (cfg_i.number_nonblank ? ~cur_empty : cfg_i.number_all);

    // visible form of the byte
    two = 1'b1;
    b0  = ChCaret;
    b1  = in_byte_i;
    if (cfg_i.show_ends & is_nl) begin
      b0 = ChDollar;
      b1 = ChNewline;
    end else if (cfg_i.show_tabs & (in_byte_i == ChTab)) begin
      b1 = ChUpperI;
    end else if (cfg_i.show_nonprinting & (in_byte_i < ChSpace) & ~is_nl &
                 (in_byte_i != ChTab)) begin
      b1 = in_byte_i + CaretOfs;
    end else if (cfg_i.show_nonprinting & (in_byte_i == ChDel)) begin
      b1 = ChQuestion;
    end else begin
      two = 1'b0;
      b0  = in_byte_i;
    end

    // saturating bcd increment: a digit steps when all lower digits are nine
    all_nines = 1'b1;
    low_nines = 1'b1;
    bcd_inc   = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (low_nines) begin
        bcd_inc[4*i +: 4] = (bcd_q[4*i +: 4] == 4'd9) ? 4'd0 : bcd_q[4*i +: 4] + 4'd1;
      end
      low_nines = low_nines & (bcd_q[4*i +: 4] == 4'd9);
    end
    all_nines = low_nines;
    if (all_nines) begin
      bcd_inc = bcd_q;
    end

    bcd_d        = (accept & ~drop & num) ? bcd_inc : bcd_q;
    prev_nl_d    = accept ? is_nl : prev_nl_q;
    prev_empty_d = accept ? cur_empty : prev_empty_q;

    q_push_o = accept & ~drop;
    q_data_o = {num, bcd_d, two, b1, b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_nl_q    <= 1'b1;
      prev_empty_q <= 1'b0;
      bcd_q        <= '0;
    end else begin
      prev_nl_q    <= prev_nl_d;
      prev_empty_q <= prev_empty_d;
      bcd_q        <= bcd_d;
    end
  end

endmodule

// ===== rtl/lfl_back.sv =====
// back end: walks one queued command byte by byte into the output register
// depends on lfl_pkg for byte codes
`timescale 1ns / 1ps

module lfl_back #(
  parameter int NumDigits = lfl_pkg::NumberDigits,
  parameter int EntryW    = 1 + 4 * NumDigits + 1 + 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  logic [EntryW-1:0] q_data_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);
  import lfl_pkg::*;

  localparam int PosW = $clog2(NumDigits + 3);
  localparam int DigW = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam logic [PosW-1:0] PosTab   = PosW'(NumDigits);
  localparam logic [PosW-1:0] PosBody0 = PosW'(NumDigits + 1);
  localparam logic [PosW-1:0] PosBody1 = PosW'(NumDigits + 2);
  localparam logic [PosW-1:0] PosLastD = PosW'(NumDigits - 1);

  logic                      num, two;
  logic [NumDigits-1:0][3:0] digits;
  logic [7:0]                b0, b1;

  logic            started_q, started_d;
  logic [PosW-1:0] pos_q, pos_d, pos;
  logic            lead_q, lead_d, lead, lead_now;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, byte_nx;
  logic            out_last_q, last_nx;
  logic            fire;
  logic [DigW-1:0] dig_idx;
  logic [3:0]      dig;

  assign {num, digits, two, b1, b0} = q_data_i;

  always_comb begin
    pos      = started_q ? pos_q : (num ? '0 : PosBody0);
    lead     = started_q ? lead_q : 1'b1;
    dig_idx  = DigW'(NumDigits - 1) - pos[DigW-1:0];
    dig      = digits[dig_idx];
    lead_now = lead & (dig == 4'd0) & (pos != PosLastD);
    fire     = ~q_empty_i & (~out_valid_q | pop_i);

    last_nx = 1'b0;
    if (pos == PosTab) begin
      byte_nx = ChTab;
    end else if (pos == PosBody0) begin
      byte_nx = b0;
      last_nx = ~two;
    end else if (pos == PosBody1) begin
      byte_nx = b1;
      last_nx = 1'b1;
    end else begin
      byte_nx = lead_now ? ChSpace : (ChZero + {4'd0, dig});
    end

    q_pop_o     = fire & last_nx;
    started_d   = started_q;
    pos_d       = pos_q;
    lead_d      = lead_q;
    if (fire) begin
      started_d = ~last_nx;
      pos_d     = pos + 1'b1;
      lead_d    = lead_now;
    end
    out_valid_d = fire | (out_valid_q & ~pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      pos_q       <= '0;
      lead_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      pos_q       <= pos_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= byte_nx;
      out_last_q <= last_nx;
    end
  end

  assign empty_o       = ~out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== rtl/text_cat_line_filter_top.sv =====
// top level of the text line filter: apb config registers, front, queue, back
// depends on lfl_pkg, lfl_front, lfl_fifo and lfl_back
`timescale 1ns / 1ps

// usage
//   input channel: a text byte on in_byte_i is taken at a clock edge with
//   push high and full low
//   result channel: out_byte_o / last_of_run_o hold the oldest result while
//   empty is low; it is taken at an edge with pop high and empty low.
//   last_of_run_o marks the final result byte of one input item; a squeezed
//   blank line gives no result at all
//   config: six one-bit apb registers at byte addresses 0,4,..,20; pready
//   is always high; they are to be written only while the block is idle,
//   a rule for the user that the block itself does not enforce
//   path: a result goes through the command queue, then the output register
//   throughput: the back emits one result byte per cycle while a command is
//   queued and pop or empty is high; an item gives 1 result byte if plain,
//   2 for caret or dollar forms, plus NUMBER_DIGITS+1 for a line-number
//   prefix; the front takes one item per cycle while the 4-deep queue has room
//   reset: config clears, the line counter goes to zero, the next byte starts
//   a line, queue and output register empty
//   stall: with pop low the output register holds; the queue then fills and
//   full rises, back-pressuring the input

module text_cat_line_filter_top #(
  parameter int NUMBER_DIGITS = lfl_pkg::NumberDigits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);
  import lfl_pkg::*;

  // command: number flag, bcd snapshot, two-byte flag, two body bytes
  localparam int EntryW = 1 + 4 * NUMBER_DIGITS + 1 + 16;

  cfg_t        cfg_q, cfg_d;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        q_push, q_pop;
  logic [EntryW-1:0] q_wdata, q_rdata;
  q_status_t   q_stat;

  // register file, index from the word address
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegSqueezeBlank:   cfg_d.squeeze_blank    = pwdata[0];
        RegNumberAll:      cfg_d.number_all       = pwdata[0];
        RegNumberNonblank: cfg_d.number_nonblank  = pwdata[0];
        RegShowEnds:       cfg_d.show_ends        = pwdata[0];
        RegShowTabs:       cfg_d.show_tabs        = pwdata[0];
        RegShowNonprint:   cfg_d.show_nonprinting = pwdata[0];
        default:           cfg_d = cfg_q; // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSqueezeBlank:   prdata = {31'd0, cfg_q.squeeze_blank};
      RegNumberAll:      prdata = {31'd0, cfg_q.number_all};
      RegNumberNonblank: prdata = {31'd0, cfg_q.number_nonblank};
      RegShowEnds:       prdata = {31'd0, cfg_q.show_ends};
      RegShowTabs:       prdata = {31'd0, cfg_q.show_tabs};
      RegShowNonprint:   prdata = {31'd0, cfg_q.show_nonprinting};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front classifies each byte and keeps line and counter state
  lfl_front #(
    .NumDigits (NUMBER_DIGITS),
    .EntryW    (EntryW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .in_byte_i (in_byte_i),
    .q_full_i  (q_stat.full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  assign full = q_stat.full;

  // decouples the front from output stalls
  lfl_fifo #(
    .Width (EntryW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_stat)
  );

  // back turns a command into prefix digits, tab and body bytes
  lfl_back #(
    .NumDigits (NUMBER_DIGITS),
    .EntryW    (EntryW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_stat.empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // queue status is never full and empty at once
  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // the back only retires a command that is present
  a_q_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("back retired a command from an empty queue");

  // the front only queues a command when there is room
  a_q_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("front queued a command into a full queue");

  // an accepted item leaves a command behind while squeezing is off
  a_nl_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !cfg_q.squeeze_blank) |-> q_push)
    else $error("accepted item produced no command without squeezing");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for text_cat_line_filter_top: byte stream in, formatted bytes out
// holds its own line filter predictor; depends on lfl_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
  import lfl_pkg::*;

  localparam int Digits     = NumberDigits;
  localparam int CycleLimit = 200_000;
  localparam int IdleGap    = 12;      // cycles of quiet after the last expected byte is out
  localparam int MaxReports = 40;

  // register indexes six and seven hold no register
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct {
    logic [7:0] ch;
    logic       run_end;
  } out_item_t;

  typedef enum int {PopAlways, PopCoin, PopSparse, PopPeriodic} pop_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        push, full;
  logic [7:0]  in_byte_i;
  logic        empty, pop;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;

  // predictor state: config copy, line position, decimal line counter
  cfg_t                  cfg_copy;
  logic                  at_line_start;
  logic                  last_line_blank;
  logic [4*Digits-1:0]   line_count_bcd;

  out_item_t pending_out[$];

  int err_cnt;
  int cycle_cnt;
  int burst_left;
  int pop_left;
  int pop_tick;
  pop_mode_e pop_mode;

  text_cat_line_filter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // expected bytes for one accepted text byte, appended to pending_out
  function automatic void format_byte(input logic [7:0] c);
    logic [7:0] run[$];
    logic       nl, blank_line, numbered, lead, saturated;
    logic [3:0] digit;
    nl         = (c == ChNewline);
    blank_line = nl && at_line_start;
    // a blank line right after a blank line vanishes when squeezing
    if (!(cfg_copy.squeeze_blank && last_line_blank && blank_line)) begin
      if (at_line_start) begin
        numbered = cfg_copy.number_nonblank ? !blank_line : cfg_copy.number_all;
        if (numbered) begin
          // bcd count up, stuck once every digit is nine
          saturated = 1'b1;
          for (int i = 0; i < Digits; i++) begin
            if (line_count_bcd[4*i +: 4] != 4'd9) saturated = 1'b0;
          end
          if (!saturated) begin
            for (int i = 0; i < Digits; i++) begin
              digit = line_count_bcd[4*i +: 4];
              if (digit == 4'd9) begin
                line_count_bcd[4*i +: 4] = 4'd0;
              end else begin
                line_count_bcd[4*i +: 4] = digit + 4'd1;
                break;
              end
            end
          end
          // right aligned, leading zeros as spaces, units digit always shown
          lead = 1'b1;
          for (int i = Digits - 1; i >= 0; i--) begin
            digit = line_count_bcd[4*i +: 4];
            if (digit != 4'd0 || i == 0) lead = 1'b0;
            run.push_back(lead ? ChSpace : ChZero + 8'(digit));
          end
          run.push_back(ChTab);
        end
      end
      if (cfg_copy.show_ends && nl) begin
        run.push_back(ChDollar);
        run.push_back(ChNewline);
      end else if (cfg_copy.show_tabs && c == ChTab) begin
        run.push_back(ChCaret);
        run.push_back(ChUpperI);
      end else if (cfg_copy.show_nonprinting && c < ChSpace && !nl && c != ChTab) begin
        run.push_back(ChCaret);
        run.push_back(c + CaretOfs);
      end else if (cfg_copy.show_nonprinting && c == ChDel) begin
        run.push_back(ChCaret);
        run.push_back(ChQuestion);
      end else begin
        run.push_back(c);
      end
    end
    at_line_start   = nl;
    last_line_blank = blank_line;
    foreach (run[k]) pending_out.push_back('{ch: run[k], run_end: (k == run.size() - 1)});
  endfunction

  function automatic void check_result(input logic [7:0] got_ch, input logic got_end);
    out_item_t exp_item;
    if (pending_out.size() == 0) begin
      if (err_cnt < MaxReports)
        $display("%0t: result with nothing expected, out_byte %02h last_of_run %0b",
                 $time, got_ch, got_end);
      err_cnt++;
    end else begin
      exp_item = pending_out.pop_front();
      if (got_ch !== exp_item.ch) begin
        if (err_cnt < MaxReports)
          $display("%0t: out_byte expected %02h actual %02h", $time, exp_item.ch, got_ch);
        err_cnt++;
      end
      if (got_end !== exp_item.run_end) begin
        if (err_cnt < MaxReports)
          $display("%0t: last_of_run expected %0b actual %0b", $time, exp_item.run_end,
                   got_end);
        err_cnt++;
      end
    end
  endfunction

  // both handshakes seen at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result(out_byte_o, last_of_run_o);
      if (push && !full) format_byte(in_byte_i);
    end
  end

  // receiver: switches between its own stall patterns after a random run length
  always @(negedge clk_i) begin
    if (pop_left == 0) begin
      pop_mode = pop_mode_e'($urandom_range(0, 3));
      pop_left = $urandom_range(20, 200);
    end
    pop_left--;
    pop_tick++;
    case (pop_mode)
      PopAlways: pop <= 1'b1;
      PopCoin:   pop <= 1'($urandom_range(0, 1));
      PopSparse: pop <= ($urandom_range(0, 3) == 0);
      default:   pop <= ((pop_tick % 6) < 2);
    endcase
  end

  // one text byte, with bursts and random gaps in between
  task automatic send_item(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    push      <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (full);
  endtask

  // stop sending, let every expected byte come out, then let the pipe empty
  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (IdleGap) @(posedge clk_i);
  endtask

  // apb write: setup, then access until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegSqueezeBlank:   cfg_copy.squeeze_blank    = value[0];
      RegNumberAll:      cfg_copy.number_all       = value[0];
      RegNumberNonblank: cfg_copy.number_nonblank  = value[0];
      RegShowEnds:       cfg_copy.show_ends        = value[0];
      RegShowTabs:       cfg_copy.show_tabs        = value[0];
      RegShowNonprint:   cfg_copy.show_nonprinting = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // all six registers, bit 0 from flags, the other bits random
  task automatic write_all_regs(input logic [5:0] flags);
    write_reg(RegSqueezeBlank,   {$urandom} & 32'hFFFF_FFFE | 32'(flags[0]));
    write_reg(RegNumberAll,      {$urandom} & 32'hFFFF_FFFE | 32'(flags[1]));
    write_reg(RegNumberNonblank, {$urandom} & 32'hFFFF_FFFE | 32'(flags[2]));
    write_reg(RegShowEnds,       {$urandom} & 32'hFFFF_FFFE | 32'(flags[3]));
    write_reg(RegShowTabs,       {$urandom} & 32'hFFFF_FFFE | 32'(flags[4]));
    write_reg(RegShowNonprint,   {$urandom} & 32'hFFFF_FFFE | 32'(flags[5]));
  endtask

  // content byte of a line, leaning on the classes the filter treats apart
  function automatic logic [7:0] line_content_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      return ChTab;
    else if (pick < 22) return 8'($urandom_range(0, 31));
    else if (pick < 27) return ChDel;
    else if (pick < 40) return 8'($urandom_range(128, 255));
    else                return 8'($urandom_range(32, 126));
  endfunction

  // defaults after reset: every byte passes untouched
  task automatic test_plain_bytes();
    send_item(8'h00);
    send_item(8'hFF);
    send_item(ChTab);
    send_item(ChDel);
    send_item(8'h1F);
    send_item(ChNewline);
  endtask

  // caret, dollar and tab forms; tab stays plain when only control bytes are shown
  task automatic test_visible_forms();
    wait_idle();
    write_reg(RegShowEnds, 32'hFFFF_FFFF);
    write_reg(RegShowTabs, 32'h0000_0001);
    write_reg(RegShowNonprint, 32'h8000_0001);
    // no register behind these, the writes must change nothing
    write_reg(RegSpareLo, 32'hFFFF_FFFF);
    write_reg(RegSpareHi, 32'h0000_0001);
    send_item(8'h00);
    send_item(8'h1F);
    send_item(ChTab);
    send_item(ChDel);
    send_item(8'h80);
    send_item(ChNewline);
    send_item(8'h7E);
    wait_idle();
    write_reg(RegShowTabs, 32'hFFFF_FFFE);
    send_item(ChTab);
  endtask

  // numbered lines with squeezing, then blank lines left without a number
  task automatic test_numbering_squeeze();
    wait_idle();
    write_reg(RegShowEnds, 32'h0000_0000);
    write_reg(RegShowNonprint, 32'h7FFF_FFFE);
    write_reg(RegSqueezeBlank, 32'h0000_0001);
    write_reg(RegNumberAll, 32'h0000_0001);
    send_item(ChNewline);
    send_item(8'h78);
    send_item(ChNewline);
    send_item(ChNewline);
    send_item(ChNewline);
    send_item(8'h79);
    send_item(ChNewline);
    wait_idle();
    write_reg(RegNumberNonblank, 32'h0000_0001);
    send_item(ChNewline);
    send_item(8'h7A);
    send_item(ChNewline);
  endtask

  // phases of random lines under changing settings, all off first and all on last
  task automatic test_random_text();
    int sent, quota, len, blanks;
    logic [5:0] flags;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      if (phase == 0)      flags = 6'b000000;
      else if (phase == 5) flags = 6'b111111;
      else                 flags = 6'($urandom);
      write_all_regs(flags);
      sent  = 0;
      quota = 55;
      while (sent < quota) begin
        // once, hold off until the block has caught up completely
        if (phase == 2 && sent >= quota / 2 && sent < quota / 2 + 4) begin
          wait_idle();
          sent = quota / 2 + 4;
        end
        if ($urandom_range(0, 9) == 0) begin
          // noise: any byte at all
          send_item(8'($urandom_range(0, 255)));
          sent++;
        end else if ($urandom_range(0, 5) == 0) begin
          // a run of blank lines for squeezing and blank numbering
          blanks = $urandom_range(1, 4);
          repeat (blanks) send_item(ChNewline);
          sent += blanks;
        end else begin
          len = $urandom_range(0, 10);
          repeat (len) send_item(line_content_byte());
          send_item(ChNewline);
          sent += len + 1;
        end
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    push       = 1'b0;
    in_byte_i  = '0;
    pop        = 1'b0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    burst_left = 0;
    pop_left   = 0;
    pop_tick   = 0;
    pop_mode   = PopAlways;
    // predictor matches the block after reset
    cfg_copy        = '0;
    at_line_start   = 1'b1;
    last_line_blank = 1'b0;
    line_count_bcd  = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_bytes();
    test_visible_forms();
    test_numbering_squeeze();
    test_random_text();

    // everything out, then a quiet tail to catch stray results
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfl_pkg.sv
rtl/lfl_fifo.sv
rtl/lfl_front.sv
rtl/lfl_back.sv
rtl/text_cat_line_filter_top.sv
bench/tb_top.sv
